// ----- hw/rtl/brm_pkg.sv -----
`default_nettype none

package brm_pkg;

  // Instruction codes. Codes from 14 up only advance the program counter and the executed count.
  localparam logic [7:0] OP_HALT = 8'd0;
  localparam logic [7:0] OP_ADDA = 8'd1;
  localparam logic [7:0] OP_ADDV = 8'd2;
  localparam logic [7:0] OP_SUBA = 8'd3;
  localparam logic [7:0] OP_SUBV = 8'd4;
  localparam logic [7:0] OP_JMPA = 8'd5;
  localparam logic [7:0] OP_JMPV = 8'd6;
  localparam logic [7:0] OP_JMPI = 8'd7;
  localparam logic [7:0] OP_SETA = 8'd8;
  localparam logic [7:0] OP_SETV = 8'd9;
  localparam logic [7:0] OP_PTRA = 8'd10;
  localparam logic [7:0] OP_PTRV = 8'd11;
  localparam logic [7:0] OP_LOAD = 8'd12;
  localparam logic [7:0] OP_STOR = 8'd13;

  localparam logic [7:0]  PC_STEP   = 8'd2;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand;
  } brm_cmd_t;

  typedef struct packed {
    logic [7:0]  next_pc;
    logic        halted;
    logic [2:0]  pointer;
    logic [7:0]  selected_value;
    logic [31:0] executed_count;
  } brm_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/byte_register_machine_step_top.sv -----
`default_nettype none

// Channel  Signals                        Word
// -------  -----------------------------  ------------------------------------------
// cmd      cmd_valid, cmd_ready, cmd      one fetched instruction (opcode, operand)
// rsp      rsp_valid, rsp_ready, rsp      machine state after that instruction
//
// An instruction is taken into the execute register, and its result word is
// then loaded into the output register. One instruction is accepted per cycle
// while the output does not stall. The exception is ptra, which needs a second
// register file read (the register it points to) and holds the execute stage
// while it does so. Reset is synchronous and active high; it clears the valid
// bits of the register file and data RAM at once, so the block takes words in
// the first cycle after reset. A stalled output only holds the execute stage
// while the result word in the output register waits.

module byte_register_machine_step_top #(
  parameter int NUM_REGS  = 8,
  parameter int RAM_DEPTH = 256
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cmd_valid,
  output logic                   cmd_ready,
  input  wire brm_pkg::brm_cmd_t cmd,
  output logic                   rsp_valid,
  input  wire                    rsp_ready,
  output brm_pkg::brm_rsp_t      rsp
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int AW = $clog2(RAM_DEPTH);

  // Moduli and their rounded-up reciprocals scaled by 2^16. For any byte and
  // a modulus of at most 256 the scaled product gives the exact quotient.
  localparam logic [8:0]  REG_MOD   = 9'(NUM_REGS);
  localparam logic [16:0] REG_RECIP = 17'((65535 + NUM_REGS) / NUM_REGS);
  localparam logic [8:0]  RAM_MOD   = 9'(RAM_DEPTH);
  localparam logic [16:0] RAM_RECIP = 17'((65535 + RAM_DEPTH) / RAM_DEPTH);

  // Reduces an 8-bit value modulo a constant: the quotient comes from a
  // multiplication by the reciprocal, and the remainder is what is left over.
  // A power-of-two modulus folds down to a mask.
  function automatic logic [7:0] mod_byte(input logic [7:0] v, input logic [8:0] m,
                                          input logic [16:0] recip);
    logic [24:0] prod;
    logic [7:0]  quo;
    logic [16:0] back;
    prod = 25'(v) * 25'(recip);
    quo  = prod[23:16];
    back = 17'(quo) * 17'(m);
    return v - back[7:0];
  endfunction

  // Storage. The arrays hold no reset; the valid bits stand in for the zero fill.
  logic [7:0]           reg_mem [NUM_REGS];
  logic [NUM_REGS-1:0]  reg_vld;
  logic [7:0]           ram_mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] ram_vld;

  // Architectural state. cur_sel always mirrors the register named by ptr.
  logic [7:0]    pc;
  logic [RW-1:0] ptr;
  logic [7:0]    cur_sel;
  logic          running;
  logic [31:0]   step_count;

  // Execute stage.
  logic              s1_valid;
  logic              s1_phase;
  brm_pkg::brm_cmd_t s1_cmd;
  logic [7:0]        rb_q;
  logic              rb_qv;
  logic              rb_byp;
  logic [7:0]        rb_byp_q;
  logic [7:0]        ra_q;
  logic              ra_qv;
  logic [7:0]        ram_q;
  logic              ram_qv;
  logic              ram_byp;
  logic [7:0]        ram_byp_q;

  logic cmd_fire;
  logic s1_wait;
  logic s1_fire;

  logic [7:0]    rd_idx8;
  logic [RW-1:0] rb_addr;
  logic [7:0]    ram_rd8;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_wr8;
  logic [AW-1:0] ram_wr_addr;
  logic [7:0]    opd_idx8;
  logic [7:0]    rv_idx8;
  logic [RW-1:0] ra_addr;

  logic [7:0] rv;
  logic [7:0] ramv;
  logic [7:0] rav;

  logic          reg_we;
  logic [7:0]    reg_wd;
  logic          ram_we;
  logic          jump;
  logic [7:0]    target;
  logic [7:0]    pc_next;
  logic [RW-1:0] ptr_next;
  logic [7:0]    sel_next;
  logic          running_next;
  logic [31:0]   count_next;
  logic [RW+2:0] ptr_wide;
  brm_pkg::brm_rsp_t rsp_next;

  assign cmd_fire  = cmd_valid && cmd_ready;
  assign s1_wait   = s1_valid && (s1_cmd.opcode == brm_pkg::OP_PTRA) && !s1_phase;
  assign s1_fire   = s1_valid && !s1_wait && (!rsp_valid || rsp_ready);
  assign cmd_ready = !s1_valid || s1_fire;

  assign rd_idx8     = mod_byte(cmd.operand, REG_MOD, REG_RECIP);
  assign rb_addr     = rd_idx8[RW-1:0];
  assign ram_rd8     = mod_byte(cmd.operand, RAM_MOD, RAM_RECIP);
  assign ram_rd_addr = ram_rd8[AW-1:0];
  assign ram_wr8     = mod_byte(s1_cmd.operand, RAM_MOD, RAM_RECIP);
  assign ram_wr_addr = ram_wr8[AW-1:0];
  assign opd_idx8    = mod_byte(s1_cmd.operand, REG_MOD, REG_RECIP);

  // Read data with the write of the edge that read it forwarded, and entries
  // that were never written reading as zero.
  assign rv      = rb_byp ? rb_byp_q : (rb_qv ? rb_q : 8'd0);
  assign ramv    = ram_byp ? ram_byp_q : (ram_qv ? ram_q : 8'd0);
  assign rav     = ra_qv ? ra_q : 8'd0;
  assign rv_idx8 = mod_byte(rv, REG_MOD, REG_RECIP);
  assign ra_addr = rv_idx8[RW-1:0];

  always_comb begin
    reg_we       = 1'b0;
    reg_wd       = cur_sel;
    ram_we       = 1'b0;
    jump         = 1'b0;
    target       = 8'd0;
    ptr_next     = ptr;
    sel_next     = cur_sel;
    running_next = running;
    count_next   = step_count;
    pc_next      = pc;
    if (running) begin
      if (step_count != brm_pkg::COUNT_MAX) begin
        count_next = step_count + 32'd1;
      end
      case (s1_cmd.opcode)
        brm_pkg::OP_HALT: begin
          running_next = 1'b0;
        end
        brm_pkg::OP_ADDA: begin
          reg_we = 1'b1;
          reg_wd = cur_sel + rv;
        end
        brm_pkg::OP_ADDV: begin
          reg_we = 1'b1;
          reg_wd = cur_sel + s1_cmd.operand;
        end
        brm_pkg::OP_SUBA: begin
          reg_we = 1'b1;
          reg_wd = cur_sel - rv;
        end
        brm_pkg::OP_SUBV: begin
          reg_we = 1'b1;
          reg_wd = cur_sel - s1_cmd.operand;
        end
        brm_pkg::OP_JMPA: begin
          jump   = 1'b1;
          target = rv;
        end
        brm_pkg::OP_JMPV: begin
          jump   = 1'b1;
          target = s1_cmd.operand;
        end
        brm_pkg::OP_JMPI: begin
          if (cur_sel == 8'd0) begin
            jump   = 1'b1;
            target = s1_cmd.operand;
          end
        end
        brm_pkg::OP_SETA: begin
          reg_we = 1'b1;
          reg_wd = rv;
        end
        brm_pkg::OP_SETV: begin
          reg_we = 1'b1;
          reg_wd = s1_cmd.operand;
        end
        brm_pkg::OP_PTRA: begin
          ptr_next = ra_addr;
          sel_next = rav;
        end
        brm_pkg::OP_PTRV: begin
          // The operand read already fetched the newly selected register.
          ptr_next = opd_idx8[RW-1:0];
          sel_next = rv;
        end
        brm_pkg::OP_LOAD: begin
          reg_we = 1'b1;
          reg_wd = ramv;
        end
        brm_pkg::OP_STOR: begin
          ram_we = 1'b1;
        end
        default: begin
        end
      endcase
      if (reg_we) begin
        sel_next = reg_wd;
      end
      pc_next = jump ? {target[6:0], 1'b0} : pc + brm_pkg::PC_STEP;
    end
  end

  assign ptr_wide = (RW + 3)'(ptr_next);

  always_comb begin
    rsp_next.next_pc        = pc_next;
    rsp_next.halted         = !running_next;
    rsp_next.pointer        = ptr_wide[2:0];
    rsp_next.selected_value = sel_next;
    rsp_next.executed_count = count_next;
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= 8'd0;
      ptr        <= '0;
      cur_sel    <= 8'd0;
      running    <= 1'b1;
      step_count <= 32'd0;
      s1_valid   <= 1'b0;
      s1_phase   <= 1'b0;
      rsp_valid  <= 1'b0;
      reg_vld    <= '0;
      ram_vld    <= '0;
    end else begin
      if (s1_fire) begin
        pc         <= pc_next;
        ptr        <= ptr_next;
        cur_sel    <= sel_next;
        running    <= running_next;
        step_count <= count_next;
        if (reg_we) begin
          reg_vld[ptr] <= 1'b1;
        end
        if (ram_we) begin
          ram_vld[ram_wr_addr] <= 1'b1;
        end
      end
      if (cmd_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (cmd_fire || s1_fire) begin
        s1_phase <= 1'b0;
      end else if (s1_wait) begin
        s1_phase <= 1'b1;
      end
      if (s1_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Register file: one write port, operand read at accept, pointer-target read
  // while ptra waits in the execute stage.
  always_ff @(posedge clk) begin
    if (s1_fire && reg_we) begin
      reg_mem[ptr] <= reg_wd;
    end
    if (cmd_fire) begin
      rb_q <= reg_mem[rb_addr];
    end
    if (s1_wait) begin
      ra_q <= reg_mem[ra_addr];
    end
  end

  // Data RAM: one write port, one read port used at accept.
  always_ff @(posedge clk) begin
    if (s1_fire && ram_we) begin
      ram_mem[ram_wr_addr] <= cur_sel;
    end
    if (cmd_fire) begin
      ram_q <= ram_mem[ram_rd_addr];
    end
  end

  // Execute stage payload, valid bits of the reads and forwarding of the write
  // that happens at the accepting edge.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_cmd    <= cmd;
      rb_qv     <= reg_vld[rb_addr];
      rb_byp    <= s1_fire && reg_we && (ptr == rb_addr);
      rb_byp_q  <= reg_wd;
      ram_qv    <= ram_vld[ram_rd_addr];
      ram_byp   <= s1_fire && ram_we && (ram_wr_addr == ram_rd_addr);
      ram_byp_q <= cur_sel;
    end
    if (s1_wait) begin
      ra_qv <= reg_vld[ra_addr];
    end
    if (s1_fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ----- verif/brm_step_checker.sv -----
`default_nettype none

module brm_step_checker (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cmd_valid,
  input  wire                    cmd_ready,
  input  wire brm_pkg::brm_cmd_t cmd,
  input  wire                    rsp_valid,
  input  wire                    rsp_ready,
  input  wire brm_pkg::brm_rsp_t rsp,
  output int                     errors,
  output int                     pending
);

  // Machine state as the instructions seen so far leave it.
  logic [7:0]  mach_pc;
  logic [2:0]  mach_ptr;
  logic [7:0]  mach_regs [8];
  logic [7:0]  mach_ram [256];
  logic        mach_running;
  logic [31:0] mach_count;

  brm_pkg::brm_rsp_t expected_states [$];
  int                mismatch_count = 0;

  // Executes one instruction word on the machine state and returns the state
  // word the block should report for it.
  function automatic brm_pkg::brm_rsp_t step_machine(brm_pkg::brm_cmd_t c);
    logic [7:0]        sel;
    logic [7:0]        rv;
    logic [7:0]        target;
    logic              jump;
    brm_pkg::brm_rsp_t r;
    if (mach_running) begin
      sel    = mach_regs[mach_ptr];
      rv     = mach_regs[c.operand[2:0]];
      target = c.operand;
      jump   = 1'b0;
      if (mach_count != brm_pkg::COUNT_MAX) mach_count = mach_count + 32'd1;
      case (c.opcode)
        brm_pkg::OP_HALT: mach_running = 1'b0;
        brm_pkg::OP_ADDA: mach_regs[mach_ptr] = sel + rv;
        brm_pkg::OP_ADDV: mach_regs[mach_ptr] = sel + c.operand;
        brm_pkg::OP_SUBA: mach_regs[mach_ptr] = sel - rv;
        brm_pkg::OP_SUBV: mach_regs[mach_ptr] = sel - c.operand;
        brm_pkg::OP_JMPA: begin
          jump   = 1'b1;
          target = rv;
        end
        brm_pkg::OP_JMPV: jump = 1'b1;
        brm_pkg::OP_JMPI: jump = (sel == 8'd0);
        brm_pkg::OP_SETA: mach_regs[mach_ptr] = rv;
        brm_pkg::OP_SETV: mach_regs[mach_ptr] = c.operand;
        brm_pkg::OP_PTRA: mach_ptr = rv[2:0];
        brm_pkg::OP_PTRV: mach_ptr = c.operand[2:0];
        brm_pkg::OP_LOAD: mach_regs[mach_ptr] = mach_ram[c.operand];
        brm_pkg::OP_STOR: mach_ram[c.operand] = sel;
        default: ;
      endcase
      mach_pc = jump ? {target[6:0], 1'b0} : mach_pc + brm_pkg::PC_STEP;
    end
    r.next_pc        = mach_pc;
    r.halted         = !mach_running;
    r.pointer        = mach_ptr;
    r.selected_value = mach_regs[mach_ptr];
    r.executed_count = mach_count;
    return r;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    brm_pkg::brm_rsp_t want;
    if (rst) begin
      mach_pc      = 8'd0;
      mach_ptr     = 3'd0;
      mach_regs    = '{default: 8'd0};
      mach_ram     = '{default: 8'd0};
      mach_running = 1'b1;
      mach_count   = 32'd0;
      expected_states.delete();
    end else begin
      if (cmd_valid && cmd_ready) expected_states.push_back(step_machine(cmd));
      if (rsp_valid && rsp_ready) begin
        if (expected_states.size() == 0) begin
          $display("%0t: result word %h arrived with nothing expected", $time, rsp);
          mismatch_count++;
        end else begin
          want = expected_states.pop_front();
          if (rsp.next_pc !== want.next_pc)
            report_field("next_pc", 32'(want.next_pc), 32'(rsp.next_pc));
          if (rsp.halted !== want.halted)
            report_field("halted", 32'(want.halted), 32'(rsp.halted));
          if (rsp.pointer !== want.pointer)
            report_field("pointer", 32'(want.pointer), 32'(rsp.pointer));
          if (rsp.selected_value !== want.selected_value)
            report_field("selected_value", 32'(want.selected_value),
                         32'(rsp.selected_value));
          if (rsp.executed_count !== want.executed_count)
            report_field("executed_count", want.executed_count, rsp.executed_count);
        end
      end
    end
    errors  <= mismatch_count;
    pending <= expected_states.size();
  end

endmodule

`default_nettype wire

// ----- verif/byte_register_machine_step_top_tb.sv -----
`default_nettype none

module byte_register_machine_step_top_tb;

  // Number of random instruction words sent after the directed program.
  localparam int RANDOM_WORDS = 1125;

  logic              clk;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_ready;
  brm_pkg::brm_cmd_t cmd;
  logic              rsp_valid;
  logic              rsp_ready;
  brm_pkg::brm_rsp_t rsp;

  int check_errors;
  int check_pending;

  // When set, the sender puts no gaps between words, so that stretches of
  // back-to-back instructions run through the pipeline.
  logic quiet;

  byte_register_machine_step_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // The checker watches both channels, runs its own copy of the machine and
  // compares every result word. It reports how many words are still owed.
  brm_step_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (check_errors),
    .pending   (check_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Even with every word waiting out the longest sender gap and the longest
  // output stall, the run stays far below this bound.
  initial begin
    #5_000_000;
    $display("byte_register_machine_step_top_tb NOT OK");
    $finish;
  end

  // Output side back-pressure, as a series of held random decisions: mostly
  // short bursts of ready and short stalls, now and then a long stall, and
  // now and then a long open stretch with no stall at all.
  initial begin
    int   hold;
    int   pick;
    logic level;
    rsp_ready <= 1'b0;
    hold = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          level = 1'b1;
          hold  = $urandom_range(20, 80);
        end else if (pick < 55) begin
          level = 1'b1;
          hold  = $urandom_range(1, 4);
        end else if (pick < 93) begin
          level = 1'b0;
          hold  = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          hold  = $urandom_range(5, 40);
        end
      end
      rsp_ready <= level;
      hold--;
    end
  end

  // Sends one instruction word. A random gap goes before it unless the
  // sender is in a quiet stretch; the word is then held until it is taken.
  task automatic send_word(input logic [7:0] op, input logic [7:0] arg);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 50) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 30);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= '{opcode: op, operand: arg};
    do @(posedge clk); while (!cmd_ready);
  endtask

  // Stops sending and waits until the block has returned every result word
  // owed so far. The first edge is always taken so that the checker has seen
  // the last accepted word before its count is read.
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (check_pending != 0);
  endtask

  initial begin
    int         pick;
    logic [7:0] op;
    logic [7:0] arg;

    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    quiet     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed program. Register 0 is selected after reset. It wraps the
    // selected register upward and downward and tries the conditional
    // jump both taken and not taken.
    send_word(brm_pkg::OP_SETV, 8'hFF);
    send_word(brm_pkg::OP_ADDV, 8'h01);
    send_word(brm_pkg::OP_JMPI, 8'h05);
    send_word(brm_pkg::OP_SUBV, 8'h01);
    send_word(brm_pkg::OP_JMPI, 8'h07);
    // A pointer value wider than three bits keeps only its low bits, which
    // selects register 7 here; register index 15 also names register 7.
    send_word(brm_pkg::OP_PTRV, 8'hFF);
    send_word(brm_pkg::OP_SETV, 8'h80);
    send_word(brm_pkg::OP_ADDA, 8'h00);
    send_word(brm_pkg::OP_SUBA, 8'h0F);
    // Store at both ends of the data RAM, then read one back and read an
    // address that was never written, which still holds zero.
    send_word(brm_pkg::OP_SETV, 8'hA5);
    send_word(brm_pkg::OP_STOR, 8'hFF);
    send_word(brm_pkg::OP_STOR, 8'h00);
    send_word(brm_pkg::OP_PTRV, 8'h03);
    send_word(brm_pkg::OP_LOAD, 8'hFF);
    send_word(brm_pkg::OP_LOAD, 8'h80);
    // Pointer taken from a register value, copy between registers, and
    // jumps, some of whose doubled targets wrap past the top of the address space.
    send_word(brm_pkg::OP_SETV, 8'hFE);
    send_word(brm_pkg::OP_PTRA, 8'h03);
    send_word(brm_pkg::OP_SETA, 8'h0B);
    send_word(brm_pkg::OP_JMPA, 8'h06);
    send_word(brm_pkg::OP_JMPV, 8'hFF);
    send_word(brm_pkg::OP_JMPV, 8'h00);
    // Codes past the last instruction only move the program counter and the executed count on.
    send_word(8'd14, 8'h00);
    send_word(8'd255, 8'hFF);
    send_word(8'h5A, 8'hA5);

    // Let the pipeline empty completely once before the random part.
    drain();

    // Random instructions. Halt is kept out, since after a halt the block
    // ignores everything. Most words are real instructions; operands favor
    // zero and small values so that registers reach zero for the conditional
    // jump and loads hit RAM addresses that were written before.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n % 300 == 150) drain();
      pick = $urandom_range(0, 99);
      if (pick < 85) op = 8'($urandom_range(1, 13));
      else op = 8'($urandom_range(14, 255));
      pick = $urandom_range(0, 99);
      if (pick < 10) arg = 8'h00;
      else if (pick < 40) arg = 8'($urandom_range(0, 15));
      else arg = 8'($urandom_range(0, 255));
      send_word(op, arg);
    end

    // Halt still counts and still advances the program counter. The words
    // after it must leave the state alone and just report it.
    send_word(brm_pkg::OP_HALT, 8'($urandom_range(0, 255)));
    send_word(brm_pkg::OP_SETV, 8'h3C);
    send_word(brm_pkg::OP_JMPV, 8'h10);
    send_word(brm_pkg::OP_HALT, 8'h00);

    drain();
    repeat (10) @(posedge clk);

    if (check_errors == 0 && check_pending == 0) begin
      $display("byte_register_machine_step_top_tb OK");
    end else begin
      $display("byte_register_machine_step_top_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/brm_pkg.sv
hw/rtl/byte_register_machine_step_top.sv
verif/brm_step_checker.sv
verif/byte_register_machine_step_top_tb.sv
